[rtl/core/cht_pkg.sv]
package cht_pkg;

    // Width of the reported chain position; wider positions wrap.
    localparam int POS_W = 7;

    // Operation codes carried on s_axis_tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_HEAD_RD,
        ST_HEAD_USE,
        ST_WALK,
        ST_RESP
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;        // capture the input transfer
        logic hash_step;   // fold one key byte into the bucket remainder
        logic head_rd;     // read the bucket head
        logic ins_write;   // link a new node at the chain head
        logic walk_start;  // read the first node of the chain
        logic walk_step;   // follow the link to the next node
        logic res_load;    // latch the outcome of the operation
        logic res_found;
        logic res_full;
        logic out_load;    // move the outcome into the output register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic hash_last;   // last key byte is being folded
        logic is_search;
        logic full;        // node pool exhausted
        logic head_empty;  // bucket chain is empty
        logic key_match;   // node just read holds the key
        logic walk_end;    // no further node to visit
    } sts_t;

endpackage

[rtl/core/cht_ram.sv]
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/cht_ctrl.sv]
module cht_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  cht_pkg::sts_t sts,
    output cht_pkg::cmd_t cmd
);

    import cht_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last) begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                cmd.head_rd = 1'b1;
                state_next  = ST_HEAD_USE;
            end
            ST_HEAD_USE: begin
                if (!sts.is_search) begin
                    cmd.res_load  = 1'b1;
                    cmd.res_full  = sts.full;
                    cmd.ins_write = !sts.full;
                    state_next    = ST_RESP;
                end else if (sts.head_empty) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK: begin
                if (sts.key_match) begin
                    cmd.res_load  = 1'b1;
                    cmd.res_found = 1'b1;
                    state_next    = ST_RESP;
                end else if (sts.walk_end) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;

    a_resp_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESP && m_valid_reg && !m_axis_tready |=> state_reg == ST_RESP)
        else $error("result dropped while output stalled");

    a_hash_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_HASH && sts.hash_last |=> state_reg == ST_HEAD_RD)
        else $error("hash did not hand over to head read");

    a_outcome_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |=> state_reg == ST_RESP)
        else $error("outcome latched without entering response");

endmodule

[rtl/core/cht_dp.sv]
module cht_dp #(
    parameter int BUCKETS    = 7,
    parameter int POOL_DEPTH = 64,
    parameter int KEY_BITS   = 31
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [((KEY_BITS + 7) / 8)*8-1:0] s_axis_tdata,
    input  logic                             s_axis_tuser,
    output logic [15:0]                      m_axis_tdata,
    input  cht_pkg::cmd_t                    cmd,
    output cht_pkg::sts_t                    sts
);

    import cht_pkg::*;

    localparam int KDW    = ((KEY_BITS + 7) / 8) * 8;
    localparam int DIGITS = KDW / 8;
    localparam int DCW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int REM_W  = $clog2(BUCKETS + 1);
    localparam int WORK_W = REM_W + 8;
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW     = $clog2(POOL_DEPTH);
    localparam int LW     = $clog2(POOL_DEPTH + 1);
    localparam int CNT_W  = (LW > POS_W) ? LW : POS_W;
    localparam logic [LW-1:0] NULL_IDX = LW'(POOL_DEPTH);

    logic                func_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KDW-1:0]      key_sh_reg;
    logic [DCW-1:0]      dig_cnt_reg;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [WORK_W-1:0]   work;
    logic [LW-1:0]       nodes_used_reg;
    logic [BUCKETS-1:0]  head_vld_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic                res_found_reg, res_full_reg;
    logic [POS_W-1:0]    res_pos_reg;
    logic [15:0]         m_tdata_reg;

    logic [BW-1:0]              bucket;
    logic [LW-1:0]              head_rdata, head_val;
    logic [KEY_BITS+LW-1:0]     node_rdata;
    logic [KEY_BITS-1:0]        node_key_rd;
    logic [LW-1:0]              node_link_rd;
    logic [IW-1:0]              node_raddr;

    // Fold the top key byte into the remainder: r*256 + byte < 256*BUCKETS,
    // so eight conditional subtracts of BUCKETS<<j bring it below BUCKETS.
    always_comb begin
        work = {rem_reg, key_sh_reg[KDW-1 -: 8]};
        for (int j = 7; j >= 0; j--) begin
            if (work >= (WORK_W'(BUCKETS) << j)) begin
                work = work - (WORK_W'(BUCKETS) << j);
            end
        end
        rem_next = work[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg    <= s_axis_tuser;
            key_reg     <= s_axis_tdata[KEY_BITS-1:0];
            key_sh_reg  <= KDW'(s_axis_tdata[KEY_BITS-1:0]);
            dig_cnt_reg <= '0;
            rem_reg     <= '0;
        end else if (cmd.hash_step) begin
            key_sh_reg  <= key_sh_reg << 8;
            dig_cnt_reg <= dig_cnt_reg + 1'b1;
            rem_reg     <= rem_next;
        end
    end

    assign bucket = rem_reg[BW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodes_used_reg <= '0;
            head_vld_reg   <= '0;
        end else if (cmd.ins_write) begin
            nodes_used_reg       <= nodes_used_reg + 1'b1;
            head_vld_reg[bucket] <= 1'b1;
        end
    end

    cht_ram #(
        .WIDTH (LW),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .aclk  (aclk),
        .we    (cmd.ins_write),
        .waddr (bucket),
        .wdata (nodes_used_reg),
        .re    (cmd.head_rd),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    // An untouched bucket reads as an empty chain.
    assign head_val = head_vld_reg[bucket] ? head_rdata : NULL_IDX;

    assign node_key_rd  = node_rdata[KEY_BITS-1:0];
    assign node_link_rd = node_rdata[KEY_BITS+LW-1:KEY_BITS];
    assign node_raddr   = cmd.walk_start ? head_val[IW-1:0] : node_link_rd[IW-1:0];

    cht_ram #(
        .WIDTH (KEY_BITS + LW),
        .DEPTH (POOL_DEPTH)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (cmd.ins_write),
        .waddr (nodes_used_reg[IW-1:0]),
        .wdata ({head_val, key_reg}),
        .re    (cmd.walk_start || cmd.walk_step),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            pos_reg <= CNT_W'(1);
        end else if (cmd.walk_step) begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_found_reg <= cmd.res_found;
            res_full_reg  <= cmd.res_full;
            res_pos_reg   <= cmd.res_found ? pos_reg[POS_W-1:0] : '0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {7'd0, res_full_reg, res_pos_reg, res_found_reg};
        end
    end

    assign m_axis_tdata = m_tdata_reg;

    always_comb begin
        sts.hash_last  = (dig_cnt_reg == DCW'(DIGITS - 1));
        sts.is_search  = (func_reg == FUNC_SEARCH);
        sts.full       = (nodes_used_reg == NULL_IDX);
        sts.head_empty = (head_val >= nodes_used_reg);
        sts.key_match  = (node_key_rd == key_reg);
        sts.walk_end   = (node_link_rd >= nodes_used_reg) ||
                         (pos_reg >= CNT_W'(POOL_DEPTH));
    end

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_write |-> !sts.full)
        else $error("node written into a full pool");

    a_pool_grows_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && nodes_used_reg != $past(nodes_used_reg) |->
            nodes_used_reg == $past(nodes_used_reg) + 1'b1 && $past(cmd.ins_write))
        else $error("pool count changed without a single insert");

    a_walk_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> pos_reg < CNT_W'(POOL_DEPTH))
        else $error("chain walk ran past the pool depth");

endmodule

[rtl/core/chained_hash_table_unit.sv]
// Hash table with separate chaining over a fixed pool of nodes.
// Input channel (s_axis_*): s_axis_tuser selects the operation (0 insert,
// 1 search) and s_axis_tdata carries the key. The bucket is key modulo
// BUCKETS. An insert takes the next free node and links it at the head of
// its bucket's chain; once the pool is used up the insert is dropped and
// pool_full is returned. A search walks the chain from the head.
// Result channel (m_axis_*): one transfer per input transfer, in order,
// carrying found, the 1-based position of the first match, and pool_full.
// Timing: one item at a time. The bucket is formed one key byte per cycle,
// then the bucket head is read from its registered memory. An insert then
// finishes with its result. A search visits one node per cycle from the
// node memory's registered read port, and a chain walk visits at most
// POOL_DEPTH nodes.
// Reset empties every bucket and the pool; node memory is not cleared.
// A stalled result waits in the output register; the next item is accepted
// and processed meanwhile, and its result waits until the register frees.
module chained_hash_table_unit #(
    parameter int BUCKETS    = 7,
    parameter int POOL_DEPTH = 64,
    parameter int KEY_BITS   = 31
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((KEY_BITS + 7) / 8)*8-1:0] s_axis_tdata,  // key, zero pad
    input  logic                              s_axis_tuser,  // func
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata   // found, position[7], pool_full, pad
);

    import cht_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence each operation: hash, head read, insert or chain walk, result.
    cht_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    // Hold the key, bucket remainder, head and node memories, and the result.
    cht_dp #(
        .BUCKETS    (BUCKETS),
        .POOL_DEPTH (POOL_DEPTH),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
